>>> src/assert_macros.svh
// Assertion macros shared by the checker files.
// No dependencies; take in with a plain include.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is asserted.
`define ESLD_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("esld assertion failed");

// Clocked assertion that also holds across reset.
`define ESLD_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("esld assertion failed");

`endif

>>> src/esld_pkg.sv
// Shared types, constants and helpers for the settle lock detector.
// No dependencies.
package esld_pkg;

    localparam int ENT_W        = 16;   // Q0.16 entropy and EMA width
    localparam int FRAC_BITS    = 16;
    localparam int STAT_W       = 32;
    localparam int TICK_OUT_W   = 16;
    localparam int TICK_W_DEF   = 16;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;

    localparam logic [ENT_W-1:0] FX_ONE   = '1;
    localparam logic [ENT_W-1:0] FX_HALF  = ENT_W'(64'd1 << (FRAC_BITS - 1));
    localparam logic [ENT_W-1:0] FX_TENTH = ENT_W'(((64'd1 << FRAC_BITS) + 64'd5) / 64'd10);
    localparam logic [ENT_W-1:0] FX_FLOOR =
        ENT_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);

    localparam logic [15:0] REL_THR_RST   = 16'd655;
    localparam logic [15:0] GAIN_RST      = 16'd19661;
    localparam logic [15:0] MIN_TICKS_RST = 16'd3;
    localparam logic [15:0] MAX_TICKS_RST = 16'd50;
    localparam logic        TWO_LEVEL_RST = 1'b0;

    typedef enum logic [1:0] {
        OP_TICK,
        OP_SHOCK,
        OP_UNLOCK,
        OP_CLEAR
    } t_op;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REL_THR,
        CFG_SMOOTH_GAIN,
        CFG_MIN_TICKS,
        CFG_MAX_TICKS,
        CFG_TWO_LEVEL
    } t_cfg_idx;

    typedef struct packed {
        t_op              op;
        logic [ENT_W-1:0] entropy_combined;
        logic [ENT_W-1:0] entropy_model;
        logic [ENT_W-1:0] entropy_particle;
    } t_in_item;

    typedef struct packed {
        logic                  stable_flag;
        logic                  locked_flag;
        logic [TICK_OUT_W-1:0] ticks_locked_now;
        logic [ENT_W-1:0]      entropy_current;
        logic [ENT_W-1:0]      change_ema_out;
        logic [STAT_W-1:0]     shock_count;
        logic [STAT_W-1:0]     locked_tick_total;
        logic [STAT_W-1:0]     lock_duration_sum;
    } t_out_item;

    typedef struct packed {
        logic [ENT_W-1:0] rel_thr;
        logic [ENT_W-1:0] smooth_gain;
        logic [15:0]      min_ticks;
        logic [15:0]      max_ticks;
        logic             two_level;
    } t_cfg;

    function automatic logic [STAT_W-1:0] sat_add32(input logic [STAT_W-1:0] a,
                                                    input logic [STAT_W-1:0] b);
        logic [STAT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[STAT_W] ? {STAT_W{1'b1}} : s[STAT_W-1:0];
    endfunction

endpackage

>>> src/esld_cfg_regs.sv
// Configuration register file of the settle lock detector.
// Depends on esld_pkg.
module esld_cfg_regs
    import esld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_wr_index,
    input  logic [CFG_DATA_W-1:0] i_wr_data,
    output t_cfg                  o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_wr_en) begin
            unique case (t_cfg_idx'(i_wr_index))
                CFG_REL_THR:     n_cfg.rel_thr     = i_wr_data;
                CFG_SMOOTH_GAIN: n_cfg.smooth_gain = i_wr_data;
                CFG_MIN_TICKS:   n_cfg.min_ticks   = i_wr_data;
                CFG_MAX_TICKS:   n_cfg.max_ticks   = i_wr_data;
                CFG_TWO_LEVEL:   n_cfg.two_level   = i_wr_data[0];
                default:         n_cfg = r_cfg;   // drop writes to unused indexes
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rel_thr     <= REL_THR_RST;
            r_cfg.smooth_gain <= GAIN_RST;
            r_cfg.min_ticks   <= MIN_TICKS_RST;
            r_cfg.max_ticks   <= MAX_TICKS_RST;
            r_cfg.two_level   <= TWO_LEVEL_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> src/esld_ema_unit.sv
// One entropy channel: change EMA update and stability test against the
// relative threshold. Purely combinational. Depends on esld_pkg.
module esld_ema_unit
    import esld_pkg::*;
(
    input  logic [ENT_W-1:0] i_gain,
    input  logic [ENT_W-1:0] i_rel_thr,
    input  logic [ENT_W-1:0] i_old_ema,
    input  logic [ENT_W-1:0] i_prev,
    input  logic [ENT_W-1:0] i_entropy,
    output logic [ENT_W-1:0] o_ema,
    output logic             o_stable
);

    localparam int PW = 2 * ENT_W + 1;

    logic [ENT_W-1:0]   w_diff;
    logic [ENT_W:0]     w_rest;
    logic [PW-1:0]      w_p_new;
    logic [PW-1:0]      w_p_old;
    logic [PW-1:0]      w_sum;
    logic [2*ENT_W-1:0] w_p_thr;
    logic [ENT_W-1:0]   w_thr_raw;
    logic [ENT_W-1:0]   w_thr;

    assign w_diff = (i_entropy > i_prev) ? (i_entropy - i_prev) : (i_prev - i_entropy);

    // weight of the old value: unit minus gain
    assign w_rest  = {1'b1, {ENT_W{1'b0}}} - {1'b0, i_gain};
    assign w_p_new = PW'(i_gain) * PW'(w_diff);
    assign w_p_old = PW'(w_rest) * PW'(i_old_ema);
    assign w_sum   = w_p_new + w_p_old;
    assign o_ema   = w_sum[FRAC_BITS +: ENT_W];

    assign w_p_thr   = (2*ENT_W)'(i_rel_thr) * (2*ENT_W)'(i_entropy);
    assign w_thr_raw = w_p_thr[FRAC_BITS +: ENT_W];
    assign w_thr     = (w_thr_raw < FX_FLOOR) ? FX_FLOOR : w_thr_raw;
    assign o_stable  = (o_ema < w_thr);

endmodule

>>> src/esld_core.sv
// Lock state, statistics counters and per-item next-state logic.
// Depends on esld_pkg and esld_ema_unit.
module esld_core
    import esld_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_W_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_advance,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_result
);

    localparam int CMP_W = (TICK_COUNT_WIDTH > 16) ? TICK_COUNT_WIDTH : 16;

    logic                        r_locked,      n_locked;
    logic [TICK_COUNT_WIDTH-1:0] r_tick,        n_tick;
    logic [ENT_W-1:0]            r_prev_ent,    n_prev_ent;
    logic [ENT_W-1:0]            r_chg_ema,     n_chg_ema;
    logic [ENT_W-1:0]            r_prev_model,  n_prev_model;
    logic [ENT_W-1:0]            r_prev_part,   n_prev_part;
    logic [ENT_W-1:0]            r_model_ema,   n_model_ema;
    logic [ENT_W-1:0]            r_part_ema,    n_part_ema;
    logic [STAT_W-1:0]           r_shock_total, n_shock_total;
    logic [STAT_W-1:0]           r_lock_ticks,  n_lock_ticks;
    logic [STAT_W-1:0]           r_dur_sum,     n_dur_sum;

    logic [TICK_COUNT_WIDTH-1:0] w_tick_inc;
    logic [CMP_W-1:0]            w_tick_inc_ext;
    logic [CMP_W-1:0]            w_tick_ext;
    logic [CMP_W-1:0]            w_min_ext;
    logic [CMP_W-1:0]            w_max_ext;
    logic [ENT_W-1:0]            w_comb_ema,  w_model_ema,  w_part_ema;
    logic                        w_comb_stb,  w_model_stb,  w_part_stb;
    logic [ENT_W:0]              w_ent_sum;
    logic [ENT_W:0]              w_ema_sum;

    esld_ema_unit u_comb (
        .i_gain    (i_cfg.smooth_gain),
        .i_rel_thr (i_cfg.rel_thr),
        .i_old_ema (r_chg_ema),
        .i_prev    (r_prev_ent),
        .i_entropy (i_item.entropy_combined),
        .o_ema     (w_comb_ema),
        .o_stable  (w_comb_stb)
    );

    esld_ema_unit u_model (
        .i_gain    (i_cfg.smooth_gain),
        .i_rel_thr (i_cfg.rel_thr),
        .i_old_ema (r_model_ema),
        .i_prev    (r_prev_model),
        .i_entropy (i_item.entropy_model),
        .o_ema     (w_model_ema),
        .o_stable  (w_model_stb)
    );

    esld_ema_unit u_part (
        .i_gain    (i_cfg.smooth_gain),
        .i_rel_thr (i_cfg.rel_thr),
        .i_old_ema (r_part_ema),
        .i_prev    (r_prev_part),
        .i_entropy (i_item.entropy_particle),
        .o_ema     (w_part_ema),
        .o_stable  (w_part_stb)
    );

    assign w_tick_inc     = (r_tick == {TICK_COUNT_WIDTH{1'b1}}) ? r_tick : r_tick + 1'b1;
    assign w_tick_inc_ext = CMP_W'(w_tick_inc);
    assign w_tick_ext     = CMP_W'(r_tick);
    assign w_min_ext      = CMP_W'(i_cfg.min_ticks);
    assign w_max_ext      = CMP_W'(i_cfg.max_ticks);
    assign w_ent_sum      = {1'b0, i_item.entropy_model} + {1'b0, i_item.entropy_particle};
    assign w_ema_sum      = {1'b0, w_model_ema} + {1'b0, w_part_ema};

    always_comb begin
        n_locked      = r_locked;
        n_tick        = r_tick;
        n_prev_ent    = r_prev_ent;
        n_chg_ema     = r_chg_ema;
        n_prev_model  = r_prev_model;
        n_prev_part   = r_prev_part;
        n_model_ema   = r_model_ema;
        n_part_ema    = r_part_ema;
        n_shock_total = r_shock_total;
        n_lock_ticks  = r_lock_ticks;
        n_dur_sum     = r_dur_sum;

        unique case (i_item.op)
            OP_TICK: begin
                if (r_locked) begin
                    n_tick       = w_tick_inc;
                    n_lock_ticks = sat_add32(r_lock_ticks, STAT_W'(1));
                    priority if (w_tick_inc_ext < w_min_ext) begin
                        // hold the lock until the minimum duration passes
                    end else if (w_tick_inc_ext >= w_max_ext) begin
                        n_locked  = 1'b0;
                        n_dur_sum = sat_add32(r_dur_sum, STAT_W'(w_tick_inc));
                    end else if (i_cfg.two_level) begin
                        n_model_ema  = w_model_ema;
                        n_part_ema   = w_part_ema;
                        n_prev_model = i_item.entropy_model;
                        n_prev_part  = i_item.entropy_particle;
                        n_prev_ent   = w_ent_sum[ENT_W:1];
                        n_chg_ema    = w_ema_sum[ENT_W:1];
                        if (w_model_stb && w_part_stb) begin
                            n_locked  = 1'b0;
                            n_dur_sum = sat_add32(r_dur_sum, STAT_W'(w_tick_inc));
                        end
                    end else begin
                        n_chg_ema  = w_comb_ema;
                        n_prev_ent = i_item.entropy_combined;
                        if (w_comb_stb) begin
                            n_locked  = 1'b0;
                            n_dur_sum = sat_add32(r_dur_sum, STAT_W'(w_tick_inc));
                        end
                    end
                end
            end
            OP_SHOCK: begin
                n_locked      = 1'b1;
                n_tick        = '0;
                n_shock_total = sat_add32(r_shock_total, STAT_W'(1));
                n_chg_ema     = FX_HALF;
                n_model_ema   = FX_HALF;
                n_part_ema    = FX_HALF;
            end
            OP_UNLOCK: begin
                if (r_locked) begin
                    n_locked  = 1'b0;
                    n_dur_sum = sat_add32(r_dur_sum, STAT_W'(r_tick));
                end
            end
            OP_CLEAR: begin
                n_shock_total = '0;
                n_lock_ticks  = '0;
                n_dur_sum     = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_locked      <= 1'b0;
            r_tick        <= '0;
            r_prev_ent    <= FX_ONE;
            r_chg_ema     <= FX_ONE;
            r_prev_model  <= '0;
            r_prev_part   <= '0;
            r_model_ema   <= FX_TENTH;
            r_part_ema    <= FX_TENTH;
            r_shock_total <= '0;
            r_lock_ticks  <= '0;
            r_dur_sum     <= '0;
        end else if (i_advance) begin
            r_locked      <= n_locked;
            r_tick        <= n_tick;
            r_prev_ent    <= n_prev_ent;
            r_chg_ema     <= n_chg_ema;
            r_prev_model  <= n_prev_model;
            r_prev_part   <= n_prev_part;
            r_model_ema   <= n_model_ema;
            r_part_ema    <= n_part_ema;
            r_shock_total <= n_shock_total;
            r_lock_ticks  <= n_lock_ticks;
            r_dur_sum     <= n_dur_sum;
        end
    end

    // the state registers double as the result register
    always_comb begin
        o_result.stable_flag       = !r_locked;
        o_result.locked_flag       = r_locked;
        o_result.ticks_locked_now  = w_tick_ext[TICK_OUT_W-1:0];
        o_result.entropy_current   = r_prev_ent;
        o_result.change_ema_out    = r_chg_ema;
        o_result.shock_count       = r_shock_total;
        o_result.locked_tick_total = r_lock_ticks;
        o_result.lock_duration_sum = r_dur_sum;
    end

endmodule

>>> src/entropy_settle_lock_detector.sv
// Top level of the settle lock detector: input register, handshake control,
// configuration registers and core. Depends on esld_pkg, esld_cfg_regs, esld_core.
//
//   channel | direction | handshake                 | payload
//   --------+-----------+---------------------------+--------------------------
//   in      | in        | i_in_valid / o_in_ready   | i_in_data  (t_in_item)
//   out     | out       | o_out_valid / i_out_ready | o_out_data (t_out_item)
//   cfg     | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// One item per cycle while the result side is not stalled; a result passes through
// the input register, then one pass of EMA multiply, add and compare into the state
// registers, which also hold the result.
// Synchronous active-low reset clears state, statistics, configuration and valids.
// While the result is stalled the input register still takes one more item.
// The configuration port is always ready.
module entropy_settle_lock_detector
    import esld_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = TICK_W_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic     r_in_vld,  n_in_vld;
    logic     r_out_vld, n_out_vld;
    t_in_item r_in;
    t_cfg     w_cfg;
    logic     w_advance;
    logic     w_in_xfer;

    assign w_advance   = r_in_vld && (!r_out_vld || i_out_ready);
    assign o_in_ready  = !r_in_vld || w_advance;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        priority if (w_in_xfer) begin
            n_in_vld = 1'b1;
        end else if (w_advance) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
        priority if (w_advance) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_in <= i_in_data;
        end
    end

    esld_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr_en    (i_cfg_valid && o_cfg_ready),
        .i_wr_index (i_cfg_index),
        .i_wr_data  (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    esld_core #(
        .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
    ) u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_item    (r_in),
        .i_cfg     (w_cfg),
        .o_result  (o_out_data)
    );

    assign o_out_valid = r_out_vld;

endmodule

>>> src/esld_checker.sv
// Port-level checks of the settle lock detector, bound to the top level.
// Depends on esld_pkg and assert_macros.svh.
`include "assert_macros.svh"

module esld_checker
    import esld_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out_item             o_out_data
);

    // a stalled result holds
    `ESLD_ASSERT_RST(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))

    // input side never stalls while the result side can move
    `ESLD_ASSERT_RST(a_in_ready_free, i_clk, i_rst_n, !o_out_valid || i_out_ready |-> o_in_ready)

    // every input transfer is followed by a valid result
    `ESLD_ASSERT_RST(a_in_to_out, i_clk, i_rst_n, i_in_valid && o_in_ready |-> ##2 o_out_valid)

    // stable and locked flags are complements
    `ESLD_ASSERT_RST(a_flags_excl, i_clk, i_rst_n, o_out_valid |-> o_out_data.stable_flag != o_out_data.locked_flag)

    // reset drops any pending result
    `ESLD_ASSERT_ALWAYS(a_rst_out, i_clk, !i_rst_n |=> !o_out_valid)

endmodule

bind entropy_settle_lock_detector esld_checker u_esld_checker (.*);

>>> sim/esld_status_checker.sv
// Status checker for the settle lock detector: follows the config, input and result
// channels, predicts the detector status for each input transfer and compares results.
// Depends on esld_pkg.
module esld_status_checker
    import esld_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  logic                  i_in_ready,
    input  t_in_item              i_in_data,
    input  logic                  i_out_valid,
    input  logic                  i_out_ready,
    input  t_out_item             i_out_data,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_mismatches,
    output int                    o_pending
);

    // configuration copy
    logic [15:0] rel_thr_q;
    logic [15:0] gain_q;
    logic [15:0] min_ticks_q;
    logic [15:0] max_ticks_q;
    logic        two_level_q;

    // detector state copy
    logic        locked_q;
    logic [15:0] ticks_q;
    logic [15:0] ent_q;
    logic [15:0] ema_q;
    logic [15:0] ent_model_q;
    logic [15:0] ent_part_q;
    logic [15:0] ema_model_q;
    logic [15:0] ema_part_q;
    logic [31:0] shocks_q;
    logic [31:0] tick_sum_q;
    logic [31:0] dur_sum_q;

    t_out_item status_q[$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
    end

    function automatic logic [31:0] stat_add(input logic [31:0] a, input logic [31:0] b);
        logic [32:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [15:0] gap_of(input logic [15:0] a, input logic [15:0] b);
        return (a > b) ? a - b : b - a;
    endfunction

    function automatic logic [15:0] smooth(input logic [15:0] old, input logic [15:0] delta);
        logic [33:0] acc;
        acc = 34'(gain_q) * 34'(delta) + ((34'd1 << FRAC_BITS) - 34'(gain_q)) * 34'(old);
        return acc[31:16];
    endfunction

    function automatic logic [15:0] stable_bound(input logic [15:0] h);
        logic [31:0] prod;
        prod = 32'(rel_thr_q) * 32'(h);
        return (prod[31:16] < FX_FLOOR) ? FX_FLOOR : prod[31:16];
    endfunction

    task automatic drop_lock();
        locked_q  = 1'b0;
        dur_sum_q = stat_add(dur_sum_q, {16'd0, ticks_q});
    endtask

    task automatic count_tick(input t_in_item it);
        logic settled;
        if (!locked_q)
            return;
        if (ticks_q != 16'hFFFF)
            ticks_q = ticks_q + 16'd1;
        tick_sum_q = stat_add(tick_sum_q, 32'd1);
        // minimum hold wins over the maximum
        if (ticks_q < min_ticks_q)
            return;
        if (ticks_q >= max_ticks_q) begin
            drop_lock();
            return;
        end
        if (two_level_q) begin
            ema_model_q = smooth(ema_model_q, gap_of(it.entropy_model, ent_model_q));
            ent_model_q = it.entropy_model;
            ema_part_q  = smooth(ema_part_q, gap_of(it.entropy_particle, ent_part_q));
            ent_part_q  = it.entropy_particle;
            settled = (ema_model_q < stable_bound(it.entropy_model)) &&
                      (ema_part_q < stable_bound(it.entropy_particle));
            ent_q = 16'((17'(it.entropy_model) + 17'(it.entropy_particle)) >> 1);
            ema_q = 16'((17'(ema_model_q) + 17'(ema_part_q)) >> 1);
        end else begin
            ema_q   = smooth(ema_q, gap_of(it.entropy_combined, ent_q));
            ent_q   = it.entropy_combined;
            settled = ema_q < stable_bound(it.entropy_combined);
        end
        if (settled)
            drop_lock();
    endtask

    task automatic advance_detector(input t_in_item it);
        t_out_item st;
        case (it.op)
            OP_TICK: begin
                count_tick(it);
            end
            OP_SHOCK: begin
                locked_q    = 1'b1;
                ticks_q     = '0;
                shocks_q    = stat_add(shocks_q, 32'd1);
                ema_q       = FX_HALF;
                ema_model_q = FX_HALF;
                ema_part_q  = FX_HALF;
            end
            OP_UNLOCK: begin
                if (locked_q)
                    drop_lock();
            end
            default: begin
                shocks_q   = '0;
                tick_sum_q = '0;
                dur_sum_q  = '0;
            end
        endcase
        st.stable_flag       = !locked_q;
        st.locked_flag       = locked_q;
        st.ticks_locked_now  = ticks_q;
        st.entropy_current   = ent_q;
        st.change_ema_out    = ema_q;
        st.shock_count       = shocks_q;
        st.locked_tick_total = tick_sum_q;
        st.lock_duration_sum = dur_sum_q;
        status_q.push_back(st);
    endtask

    function automatic void check_field(input string tag, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h actual %h", $time, tag, want, got);
            o_mismatches++;
        end
    endfunction

    task automatic check_status(input t_out_item got);
        t_out_item want;
        if (status_q.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %h", $time, got);
            o_mismatches++;
            return;
        end
        want = status_q.pop_front();
        check_field("stable_flag", 32'(want.stable_flag), 32'(got.stable_flag));
        check_field("locked_flag", 32'(want.locked_flag), 32'(got.locked_flag));
        check_field("ticks_locked_now", 32'(want.ticks_locked_now),
                    32'(got.ticks_locked_now));
        check_field("entropy_current", 32'(want.entropy_current), 32'(got.entropy_current));
        check_field("change_ema_out", 32'(want.change_ema_out), 32'(got.change_ema_out));
        check_field("shock_count", want.shock_count, got.shock_count);
        check_field("locked_tick_total", want.locked_tick_total, got.locked_tick_total);
        check_field("lock_duration_sum", want.lock_duration_sum, got.lock_duration_sum);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rel_thr_q   = REL_THR_RST;
            gain_q      = GAIN_RST;
            min_ticks_q = MIN_TICKS_RST;
            max_ticks_q = MAX_TICKS_RST;
            two_level_q = TWO_LEVEL_RST;
            locked_q    = 1'b0;
            ticks_q     = '0;
            ent_q       = FX_ONE;
            ema_q       = FX_ONE;
            ent_model_q = '0;
            ent_part_q  = '0;
            ema_model_q = FX_TENTH;
            ema_part_q  = FX_TENTH;
            shocks_q    = '0;
            tick_sum_q  = '0;
            dur_sum_q   = '0;
            status_q.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (t_cfg_idx'(i_cfg_index))
                    CFG_REL_THR:     rel_thr_q   = i_cfg_data;
                    CFG_SMOOTH_GAIN: gain_q      = i_cfg_data;
                    CFG_MIN_TICKS:   min_ticks_q = i_cfg_data;
                    CFG_MAX_TICKS:   max_ticks_q = i_cfg_data;
                    CFG_TWO_LEVEL:   two_level_q = i_cfg_data[0];
                    default: ;
                endcase
            end
            // compare before predicting so a new entry never meets a stray result
            if (i_out_valid && i_out_ready)
                check_status(i_out_data);
            if (i_in_valid && i_in_ready)
                advance_detector(i_in_data);
        end
        o_pending <= status_q.size();
    end

endmodule

>>> sim/tb_top.sv
// Top of the settle lock detector testbench: clock, reset, stimulus, sink control,
// watchdog and verdict. Depends on esld_pkg, entropy_settle_lock_detector and
// esld_status_checker.
module tb_top;
    import esld_pkg::*;

    localparam int STALL_LIMIT = 2000;
    localparam int LONG_HOLD   = 300;

    logic                  i_clk       = 1'b0;
    logic                  i_rst_n     = 1'b0;
    logic                  i_in_valid  = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data   = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b0;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data  = '0;

    int mismatches;
    int pending;
    int sent_items = 0;
    bit idle_on    = 1'b0;
    bit long_hold  = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    entropy_settle_lock_detector dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    esld_status_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_in_data    (i_in_data),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_data   (o_out_data),
        .i_cfg_valid  (i_cfg_valid),
        .i_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_mismatches (mismatches),
        .o_pending    (pending)
    );

    // Valid stays high across back-to-back transfers; it only drops for a gap.
    task automatic send_event(input t_op op, input logic [15:0] hc, input logic [15:0] hm,
                              input logic [15:0] hp);
        t_in_item it;
        if (idle_on && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge i_clk);
        end
        it.op               = op;
        it.entropy_combined = hc;
        it.entropy_model    = hm;
        it.entropy_particle = hp;
        i_in_valid <= 1'b1;
        i_in_data  <= it;
        do @(posedge i_clk); while (!o_in_ready);
        sent_items++;
    endtask

    // Hold input off until every predicted status has come back.
    task automatic quiesce();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic apply_settings(input logic [15:0] rel, input logic [15:0] gain,
                                  input logic [15:0] min_t, input logic [15:0] max_t,
                                  input logic [15:0] mode);
        quiesce();
        // unmapped indexes must leave everything alone
        write_reg(CFG_IDX_W'(5), 16'($urandom));
        write_reg(CFG_REL_THR, rel);
        write_reg(CFG_SMOOTH_GAIN, gain);
        write_reg(CFG_MIN_TICKS, min_t);
        write_reg(CFG_MAX_TICKS, max_t);
        write_reg(CFG_TWO_LEVEL, mode);
        write_reg(CFG_IDX_W'(7), 16'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    task automatic noise_event();
        send_event(t_op'($urandom_range(0, 3)), 16'($urandom), 16'($urandom),
                   16'($urandom));
    endtask

    // Shock, then ticks whose entropies wander less and less so the lock can settle.
    task automatic settle_run();
        logic [15:0] hc;
        logic [15:0] hm;
        logic [15:0] hp;
        logic [15:0] mask;
        hc   = 16'($urandom);
        hm   = 16'($urandom);
        hp   = 16'($urandom);
        mask = 16'hFFFF >> $urandom_range(4, 15);
        send_event(OP_SHOCK, 16'($urandom), 16'($urandom), 16'($urandom));
        repeat ($urandom_range(1, 45)) begin
            case ($urandom_range(0, 39))
                0: send_event(OP_UNLOCK, hc, hm, hp);
                1: send_event(OP_CLEAR, hc, hm, hp);
                2: send_event(OP_SHOCK, hc, hm, hp);
                default: send_event(OP_TICK, hc ^ (16'($urandom) & mask),
                                    hm ^ (16'($urandom) & mask),
                                    hp ^ (16'($urandom) & mask));
            endcase
            mask = mask >> 1;
        end
    endtask

    task automatic random_block(input int count);
        int start;
        start = sent_items;
        while (sent_items - start < count) begin
            if ($urandom_range(0, 3) != 0)
                settle_run();
            else
                repeat ($urandom_range(1, 4)) noise_event();
        end
    endtask

    initial begin : sink_ctrl
        @(posedge i_clk);
        forever begin
            if (long_hold) begin
                i_out_ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) ||
                (i_cfg_valid && o_cfg_ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        idle_on = 1'b1;
        send_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000);    // tick while unlocked
        send_event(OP_UNLOCK, 16'hFFFF, 16'hFFFF, 16'hFFFF);  // unlock while unlocked
        send_event(OP_CLEAR, 16'h0000, 16'hFFFF, 16'h0000);
        send_event(OP_SHOCK, 16'hFFFF, 16'h0000, 16'hFFFF);
        repeat (3) send_event(OP_TICK, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_event(OP_TICK, 16'h0000, 16'h0000, 16'h0000);
        send_event(OP_SHOCK, 16'h8000, 16'h8000, 16'h8000);   // restart while locked
        repeat (2) send_event(OP_TICK, 16'h8000, 16'h7FFF, 16'h8001);
        send_event(OP_CLEAR, 16'h0000, 16'h0000, 16'h0000);   // clear during the lock
        send_event(OP_UNLOCK, 16'h0000, 16'h0000, 16'h0000);
        send_event(OP_TICK, 16'hAAAA, 16'h5555, 16'hAAAA);

        // maximum below minimum: the minimum hold comes first
        apply_settings(16'hFFFF, 16'hFFFF, 16'd5, 16'd2, 16'h0000);
        send_event(OP_SHOCK, 16'h1234, 16'h1234, 16'h1234);
        repeat (6) send_event(OP_TICK, 16'h1234, 16'h1234, 16'h1234);

        // extremes
        apply_settings(16'hFFFF, 16'hFFFF, 16'h0000, 16'hFFFF, 16'hFFFF);
        random_block(70);
        apply_settings(16'h0000, 16'h0000, 16'h0000, 16'd20, 16'h0000);
        random_block(45);
        apply_settings(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001);
        random_block(25);

        // reset values again, with a long sink stall so the input backs up
        apply_settings(REL_THR_RST, GAIN_RST, MIN_TICKS_RST, MAX_TICKS_RST,
                       16'(TWO_LEVEL_RST));
        long_hold = 1'b1;
        random_block(70);

        repeat (2) begin
            apply_settings(16'($urandom), 16'($urandom), 16'($urandom_range(0, 6)),
                           16'($urandom_range(0, 40)), 16'($urandom));
            random_block(45);
        end

        // no idling from here on
        idle_on = 1'b0;
        apply_settings(16'($urandom_range(0, 4000)), 16'($urandom), 16'($urandom_range(0, 6)),
                       16'($urandom_range(0, 60)), 16'($urandom));
        random_block(45);

        quiesce();
        repeat (8) @(posedge i_clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
